### sv/gha_pkg.sv
// Shared constants, codes and word types of the generational handle allocator.
package gha_pkg;

   localparam int SLOT_COUNT  = 1024;
   localparam int ID_W        = $clog2(SLOT_COUNT);
   localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
   localparam int GEN_W       = 32;
   localparam int SLOT_W      = GEN_W + 1;
   localparam int HANDLE_ID_W = 10;
   localparam int LIVE_W      = 11;

   localparam logic [GEN_W-1:0] GEN_MAX   = '1;
   localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_DEAD = 2'd2;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [31:0]      entity_id;
      logic [GEN_W-1:0] entity_generation;
   } req_word_type;

   typedef struct packed {
      logic [HANDLE_ID_W-1:0] handle_id;
      logic [GEN_W-1:0]       handle_generation;
      logic                   is_alive;
      logic [1:0]             status;
      logic [LIVE_W-1:0]      live_count;
   } rsp_word_type;

endpackage

### sv/gha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/gha_gen_unit.sv
// Generation compare and wrapping increment shared by create, remove and query.
module gha_gen_unit (
   input  logic [gha_pkg::GEN_W-1:0] slot_gen,
   input  logic [gha_pkg::GEN_W-1:0] req_gen,
   output logic                      gen_match,
   output logic [gha_pkg::GEN_W-1:0] gen_next
);

   // generation zero never names a live handle
   assign gen_match = (req_gen != '0) && (slot_gen == req_gen);
   assign gen_next  = (slot_gen == gha_pkg::GEN_MAX) ? gha_pkg::GEN_FIRST
                                                     : slot_gen + gha_pkg::GEN_FIRST;

endmodule

### sv/generational_handle_allocator.sv
// A request word steps through the idle, look and execute states; its result word is registered
// when the execute step fires. The next request is taken only back in idle, after the two dependent
// reads of the free-stack memory and then the slot memory; a stalled result holds the next request.
// Reset clears the counters, the sequencer and the result valid flag only; the memories are not cleared,
// and slot entries at or above the fill count are never used.
module generational_handle_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gha_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gha_pkg::rsp_word_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   gha_pkg::req_word_type req_ff;
   logic [gha_pkg::CNT_W-1:0] free_top_ff, free_top_in;
   logic [gha_pkg::CNT_W-1:0] slots_used_ff, slots_used_in;
   logic [gha_pkg::CNT_W-1:0] live_total_ff, live_total_in;
   logic rsp_valid_ff;
   gha_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic                       stk_we;
   logic [gha_pkg::ID_W-1:0]   stk_waddr;
   logic [gha_pkg::ID_W-1:0]   stk_raddr;
   logic [gha_pkg::ID_W-1:0]   stk_rdata;
   logic                       slot_we;
   logic [gha_pkg::ID_W-1:0]   slot_waddr;
   logic [gha_pkg::SLOT_W-1:0] slot_wdata;
   logic [gha_pkg::ID_W-1:0]   slot_raddr;
   logic [gha_pkg::SLOT_W-1:0] slot_rdata;

   logic                      gen_match;
   logic [gha_pkg::GEN_W-1:0] gen_next;
   logic                      handle_ok;
   logic                      fire;
   logic [gha_pkg::CNT_W-1:0] top_dec;

   assign req_ready = (state_ff == ST_IDLE);
   assign fire      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign top_dec   = free_top_ff - gha_pkg::CNT_W'(1);
   assign stk_raddr = top_dec[gha_pkg::ID_W-1:0];
   assign slot_raddr = (req_ff.req_type == gha_pkg::REQ_CREATE) ? stk_rdata
                                                  : req_ff.entity_id[gha_pkg::ID_W-1:0];

   gha_ram #(.WIDTH(gha_pkg::ID_W), .DEPTH(gha_pkg::SLOT_COUNT)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (req_ff.entity_id[gha_pkg::ID_W-1:0]),
      .rd_en   (state_ff == ST_IDLE),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // slot word: live bit above generation
   gha_ram #(.WIDTH(gha_pkg::SLOT_W), .DEPTH(gha_pkg::SLOT_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (state_ff == ST_LOOK),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   gha_gen_unit u_gen_unit (
      .slot_gen  (slot_rdata[gha_pkg::GEN_W-1:0]),
      .req_gen   (req_ff.entity_generation),
      .gen_match (gen_match),
      .gen_next  (gen_next)
   );

   // id below the fill count also keeps it below the table size
   assign handle_ok = gen_match && slot_rdata[gha_pkg::GEN_W]
                      && (req_ff.entity_id < 32'(slots_used_ff));

   always_comb begin
      state_in      = state_ff;
      free_top_in   = free_top_ff;
      slots_used_in = slots_used_ff;
      live_total_in = live_total_ff;
      stk_we        = 1'b0;
      stk_waddr     = free_top_ff[gha_pkg::ID_W-1:0];
      slot_we       = 1'b0;
      slot_waddr    = slot_raddr;
      slot_wdata    = {1'b1, gen_next};
      rsp_data_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_IDLE;
               case (req_ff.req_type)
                  gha_pkg::REQ_CREATE: begin
                     if (free_top_ff != '0) begin
                        slot_we     = 1'b1;
                        slot_waddr  = stk_rdata;
                        slot_wdata  = {1'b1, gen_next};
                        free_top_in = top_dec;
                        live_total_in = live_total_ff + gha_pkg::CNT_W'(1);
                        rsp_data_in.handle_id = gha_pkg::HANDLE_ID_W'(stk_rdata);
                        rsp_data_in.handle_generation = gen_next;
                     end else if (slots_used_ff < gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT)) begin
                        slot_we       = 1'b1;
                        slot_waddr    = slots_used_ff[gha_pkg::ID_W-1:0];
                        slot_wdata    = {1'b1, gha_pkg::GEN_FIRST};
                        slots_used_in = slots_used_ff + gha_pkg::CNT_W'(1);
                        live_total_in = live_total_ff + gha_pkg::CNT_W'(1);
                        rsp_data_in.handle_id = gha_pkg::HANDLE_ID_W'(slots_used_ff);
                        rsp_data_in.handle_generation = gha_pkg::GEN_FIRST;
                     end else begin
                        rsp_data_in.status = gha_pkg::STATUS_FULL;
                     end
                  end
                  gha_pkg::REQ_REMOVE: begin
                     if (handle_ok && (free_top_ff < gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT))) begin
                        slot_we     = 1'b1;
                        slot_wdata  = {1'b0, slot_rdata[gha_pkg::GEN_W-1:0]};
                        stk_we      = 1'b1;
                        free_top_in = free_top_ff + gha_pkg::CNT_W'(1);
                        if (live_total_ff != '0) begin
                           live_total_in = live_total_ff - gha_pkg::CNT_W'(1);
                        end
                     end else begin
                        rsp_data_in.status = gha_pkg::STATUS_DEAD;
                     end
                  end
                  gha_pkg::REQ_QUERY: begin
                     rsp_data_in.is_alive = handle_ok;
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.live_count = gha_pkg::LIVE_W'(live_total_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_top_ff   <= '0;
         slots_used_ff <= '0;
         live_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_top_ff   <= free_top_in;
         slots_used_ff <= slots_used_in;
         live_total_ff <= live_total_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every slot ever taken is either live or waiting on the free stack
   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      (free_top_ff + live_total_ff) == slots_used_ff)
      else $error("free stack and live count do not add up to slots used");

   a_full_means_exhausted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == gha_pkg::STATUS_FULL)
      |-> (free_top_ff == '0 && slots_used_ff == gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT)))
      else $error("table full reported while a slot was available");

   a_alive_plain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.is_alive)
      |-> (rsp_data_ff.status == gha_pkg::STATUS_DONE && rsp_data_ff.handle_generation == '0))
      else $error("live query word carries create or error fields");

   a_fire_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      (slot_we || stk_we) |=> (state_ff == ST_IDLE))
      else $error("memory written outside the execute step");

endmodule

### verif/tb.sv
// Self-checking bench for the generational handle allocator: directed and random request words.
module tb;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   gha_pkg::req_word_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   gha_pkg::rsp_word_type rsp_data;

   generational_handle_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // allocator state as the bench sees it
   logic [gha_pkg::GEN_W-1:0] slot_gen [gha_pkg::SLOT_COUNT];
   bit                        slot_alive [gha_pkg::SLOT_COUNT];
   int                        freed_ids [$];
   int                        fresh_next = 0;
   int                        live_now = 0;

   gha_pkg::req_word_type     req_backlog [$];
   gha_pkg::rsp_word_type     rsp_due [$];

   int mismatches = 0;
   int n_req = 0, n_create = 0, n_reuse = 0, n_full = 0, n_remove = 0, n_refused = 0;
   int n_query = 0, n_alive = 0, n_unused = 0, peak_live = 0;
   int send_idle = 0, stall_left = 0;
   bit send_quiet = 1'b0, recv_quiet = 1'b0;

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   function automatic bit handle_alive(logic [31:0] id, logic [gha_pkg::GEN_W-1:0] gen);
      if (gen == '0 || id >= 32'(fresh_next)) return 1'b0;
      return slot_alive[id[gha_pkg::ID_W-1:0]] && slot_gen[id[gha_pkg::ID_W-1:0]] == gen;
   endfunction

   function automatic gha_pkg::rsp_word_type allocate_step(gha_pkg::req_word_type w);
      gha_pkg::rsp_word_type r;
      int s;
      r = '0;
      s = -1;
      n_req++;
      case (w.req_type)
         gha_pkg::REQ_CREATE: begin
            n_create++;
            if (freed_ids.size() > 0) begin
               // take the most recently freed slot
               s = freed_ids[$];
               freed_ids.delete(freed_ids.size() - 1);
               slot_gen[s] = (slot_gen[s] == gha_pkg::GEN_MAX) ? gha_pkg::GEN_FIRST
                                                               : slot_gen[s] + 1'b1;
               n_reuse++;
            end else if (fresh_next < gha_pkg::SLOT_COUNT) begin
               s = fresh_next;
               fresh_next++;
               slot_gen[s] = gha_pkg::GEN_FIRST;
            end else begin
               r.status = gha_pkg::STATUS_FULL;
               n_full++;
            end
            if (s >= 0) begin
               slot_alive[s] = 1'b1;
               live_now++;
               if (live_now > peak_live) peak_live = live_now;
               r.handle_id = gha_pkg::HANDLE_ID_W'(s);
               r.handle_generation = slot_gen[s];
            end
         end
         gha_pkg::REQ_REMOVE: begin
            n_remove++;
            if (handle_alive(w.entity_id, w.entity_generation)) begin
               slot_alive[w.entity_id[gha_pkg::ID_W-1:0]] = 1'b0;
               freed_ids.insert(freed_ids.size(), int'(w.entity_id[gha_pkg::ID_W-1:0]));
               live_now--;
            end else begin
               r.status = gha_pkg::STATUS_DEAD;
               n_refused++;
            end
         end
         gha_pkg::REQ_QUERY: begin
            n_query++;
            r.is_alive = handle_alive(w.entity_id, w.entity_generation);
            if (r.is_alive) n_alive++;
         end
         default: n_unused++;
      endcase
      r.live_count = gha_pkg::LIVE_W'(live_now);
      return r;
   endfunction

   // mostly back to back, sometimes a short gap, rarely a long one
   function automatic int pick_idle(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_word(logic [1:0] kind, logic [31:0] id,
                             logic [gha_pkg::GEN_W-1:0] gen);
      gha_pkg::req_word_type w;
      w.req_type = kind;
      w.entity_id = id;
      w.entity_generation = gen;
      req_backlog.insert(req_backlog.size(), w);
   endtask

   // aim removes and queries at slots already taken; the rest is noise
   task automatic add_random(int create_pct, int remove_pct, int query_pct);
      int r;
      logic [31:0] id;
      logic [gha_pkg::GEN_W-1:0] gen;
      logic [1:0] kind;
      r = $urandom_range(0, 99);
      id = $urandom;
      gen = $urandom;
      if (r < create_pct) kind = gha_pkg::REQ_CREATE;
      else if (r < create_pct + remove_pct) kind = gha_pkg::REQ_REMOVE;
      else if (r < create_pct + remove_pct + query_pct) kind = gha_pkg::REQ_QUERY;
      else if ($urandom_range(0, 1)) kind = REQ_UNUSED;
      else kind = 2'($urandom_range(gha_pkg::REQ_CREATE, gha_pkg::REQ_QUERY));
      if (r >= create_pct && r < create_pct + remove_pct + query_pct && fresh_next > 0) begin
         id = $urandom_range(0, fresh_next - 1);
         gen = slot_gen[id[gha_pkg::ID_W-1:0]];
         case ($urandom_range(0, 9))
            0: gen = gen - 1'b1;
            1: gen = gen + 1'b1;
            2: id = id | (32'd1 << $urandom_range(gha_pkg::ID_W, 31));
            default: ;
         endcase
      end
      queue_word(kind, id, gen);
   endtask

   task automatic drain_backlog();
      do @(negedge clock); while (req_backlog.size() != 0 || req_valid);
   endtask

   task automatic wait_idle();
      drain_backlog();
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // small batches so that targets come from state already settled
   task automatic run_random(int n, int create_pct, int remove_pct, int query_pct);
      for (int i = 0; i < n; i += 8) begin
         drain_backlog();
         for (int j = 0; j < 8; j++) add_random(create_pct, remove_pct, query_pct);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_idle = 0;
      end else begin
         if (req_valid && req_ready) begin
            rsp_due.insert(rsp_due.size(), allocate_step(req_data));
            if ($urandom_range(0, 149) == 0) send_quiet = !send_quiet;
            send_idle = pick_idle(send_quiet);
         end
         if (!req_valid || req_ready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_data <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      gha_pkg::rsp_word_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               flag_mismatch("result with nothing due", 64'(rsp_data), '0);
            end else begin
               due = rsp_due.pop_front();
               if (rsp_data.handle_id !== due.handle_id)
                  flag_mismatch("handle_id", 64'(rsp_data.handle_id), 64'(due.handle_id));
               if (rsp_data.handle_generation !== due.handle_generation)
                  flag_mismatch("handle_generation", 64'(rsp_data.handle_generation),
                                64'(due.handle_generation));
               if (rsp_data.is_alive !== due.is_alive)
                  flag_mismatch("is_alive", 64'(rsp_data.is_alive), 64'(due.is_alive));
               if (rsp_data.status !== due.status)
                  flag_mismatch("status", 64'(rsp_data.status), 64'(due.status));
               if (rsp_data.live_count !== due.live_count)
                  flag_mismatch("live_count", 64'(rsp_data.live_count), 64'(due.live_count));
            end
            if ($urandom_range(0, 149) == 0) recv_quiet = !recv_quiet;
            stall_left = pick_idle(recv_quiet);
         end else if (stall_left == 0 && !recv_quiet && $urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(1, 4);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_word(gha_pkg::REQ_QUERY, 0, gha_pkg::GEN_FIRST);    // nothing taken yet
      queue_word(gha_pkg::REQ_REMOVE, 0, gha_pkg::GEN_FIRST);
      queue_word(REQ_UNUSED, '1, '1);
      queue_word(gha_pkg::REQ_CREATE, '1, '1);                  // id and generation ignored
      queue_word(gha_pkg::REQ_CREATE, 0, 0);
      queue_word(gha_pkg::REQ_CREATE, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_word(gha_pkg::REQ_QUERY, 1, gha_pkg::GEN_FIRST);
      queue_word(gha_pkg::REQ_QUERY, 1, '0);                    // generation zero is never live
      queue_word(gha_pkg::REQ_QUERY, 1, 2);
      queue_word(gha_pkg::REQ_QUERY, '1, gha_pkg::GEN_FIRST);
      // upper bits alias a live slot
      queue_word(gha_pkg::REQ_QUERY, 32'h8000_0001, gha_pkg::GEN_FIRST);
      queue_word(gha_pkg::REQ_QUERY, 3, gha_pkg::GEN_FIRST);    // slot never handed out
      queue_word(gha_pkg::REQ_REMOVE, 1, 2);
      queue_word(gha_pkg::REQ_REMOVE, 1, '0);
      queue_word(gha_pkg::REQ_REMOVE, 32'h0000_0401, gha_pkg::GEN_FIRST);
      queue_word(gha_pkg::REQ_REMOVE, 1, gha_pkg::GEN_FIRST);
      queue_word(gha_pkg::REQ_REMOVE, 1, gha_pkg::GEN_FIRST);   // already freed
      queue_word(gha_pkg::REQ_QUERY, 1, gha_pkg::GEN_FIRST);
      queue_word(gha_pkg::REQ_REMOVE, 2, gha_pkg::GEN_FIRST);
      queue_word(gha_pkg::REQ_CREATE, 0, 0);                    // last freed comes back first
      queue_word(gha_pkg::REQ_CREATE, 0, 0);
      queue_word(gha_pkg::REQ_CREATE, 0, 0);                    // stack empty: fresh slot
      queue_word(gha_pkg::REQ_QUERY, 2, '1);
      queue_word(gha_pkg::REQ_QUERY, 2, 2);
      queue_word(REQ_UNUSED, 0, 0);
      wait_idle();

      run_random(64, 40, 25, 25);
      wait_idle();

      // fill the whole table, then keep creating against it, with queries and noise mixed in
      while (live_now < gha_pkg::SLOT_COUNT) begin
         drain_backlog();
         for (int j = 0; j < 16; j++) add_random(100, 0, 0);
      end
      for (int j = 0; j < 16; j++) add_random(70, 0, 20);
      drain_backlog();

      run_random(96, 25, 40, 25);

      drain_backlog();
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);

      $display("covered %0d requests: %0d creates, %0d on freed slots, %0d against a full table",
               n_req, n_create, n_reuse, n_full);
      $display("  %0d removes (%0d refused), %0d queries (%0d alive), %0d unused, peak live %0d",
               n_remove, n_refused, n_query, n_alive, n_unused, peak_live);
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #8000000;
      $display("timeout with %0d words waiting and %0d results due",
               req_backlog.size(), rsp_due.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
sv/gha_pkg.sv
sv/gha_ram.sv
sv/gha_gen_unit.sv
sv/generational_handle_allocator.sv
verif/tb.sv
